FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: rtl/i2cm_pkg.sv
// Types and constants of the I2C register transfer master.
package i2cm_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] DELAY_RESET = 8'd10;

    // Bus sequencer phases.
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_ST_A    = 5'd1;
    localparam logic [4:0] PH_ST_B    = 5'd2;
    localparam logic [4:0] PH_ST_C    = 5'd3;
    localparam logic [4:0] PH_TX_SET  = 5'd4;
    localparam logic [4:0] PH_TX_RISE = 5'd5;
    localparam logic [4:0] PH_AK_REL  = 5'd6;
    localparam logic [4:0] PH_AK_RISE = 5'd7;
    localparam logic [4:0] PH_AK_CHK  = 5'd8;
    localparam logic [4:0] PH_RX_REL  = 5'd9;
    localparam logic [4:0] PH_RX_RISE = 5'd10;
    localparam logic [4:0] PH_RX_SAMP = 5'd11;
    localparam logic [4:0] PH_MA_SET  = 5'd12;
    localparam logic [4:0] PH_MA_RISE = 5'd13;
    localparam logic [4:0] PH_MA_FALL = 5'd14;
    localparam logic [4:0] PH_SP_A    = 5'd15;
    localparam logic [4:0] PH_SP_B    = 5'd16;
    localparam logic [4:0] PH_SP_C    = 5'd17;

    // Which byte is on the wire.
    localparam logic [1:0] STG_ID   = 2'd0;
    localparam logic [1:0] STG_ADDR = 2'd1;
    localparam logic [1:0] STG_DATA = 2'd2;
    localparam logic [1:0] STG_RID  = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] device_id;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] wr_data;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       rd_last;
        logic       wr_taken;
        logic       busy_res;
        logic       done_res;
        logic       ok;
    } out_t;

    typedef struct packed {
        logic [4:0] phase;
        logic [2:0] bit_index;
        logic [7:0] bytes_left;
        logic [7:0] shift_byte;
        logic [7:0] delay_count;
        logic [7:0] held_id;
        logic [7:0] held_addr;
        logic [1:0] stage;
        logic       read_mode;
        logic       waiting;
        logic       pin_scl;
        logic       pin_sda;
        logic       pin_drv;
    } state_t;

    // Idle phase, stage ID, pins high and driven.
    localparam state_t STATE_RESET = '{
        phase:       PH_IDLE,
        bit_index:   3'd0,
        bytes_left:  8'd0,
        shift_byte:  8'd0,
        delay_count: 8'd0,
        held_id:     8'd0,
        held_addr:   8'd0,
        stage:       STG_ID,
        read_mode:   1'b0,
        waiting:     1'b0,
        pin_scl:     1'b1,
        pin_sda:     1'b1,
        pin_drv:     1'b1
    };

endpackage

FILE: rtl/i2cm_step.sv
// Next-state and result logic for one bus timing tick.
module i2cm_step (
    input  i2cm_pkg::state_t st,
    input  i2cm_pkg::in_t    tick,
    input  logic [7:0]       delay_ticks,
    output i2cm_pkg::state_t nx,
    output i2cm_pkg::out_t   res
);

    logic act;

    always_comb begin
        nx  = st;
        res = '0;
        act = 1'b0;

        if (st.phase == i2cm_pkg::PH_IDLE) begin
            if (tick.cmd == i2cm_pkg::CMD_WRITE || tick.cmd == i2cm_pkg::CMD_READ) begin
                nx.read_mode  = (tick.cmd == i2cm_pkg::CMD_READ);
                nx.held_id    = tick.device_id;
                nx.held_addr  = tick.reg_addr;
                // read of zero bytes runs as one byte
                nx.bytes_left = (nx.read_mode && tick.byte_count == 8'd0) ?
                                8'd1 : tick.byte_count;
                nx.shift_byte = tick.device_id;
                nx.stage      = i2cm_pkg::STG_ID;
                nx.bit_index  = 3'd0;
                nx.phase      = i2cm_pkg::PH_ST_A;
                act           = 1'b1;
            end
        end else if (st.waiting) begin
            if (st.delay_count == 8'd0) begin
                nx.waiting = 1'b0;
            end else begin
                nx.delay_count = st.delay_count - 8'd1;
            end
        end else begin
            act = 1'b1;
        end

        if (act) begin
            case (nx.phase)
                i2cm_pkg::PH_ST_A: begin
                    nx.pin_scl = 1'b1; nx.pin_sda = 1'b1; nx.pin_drv = 1'b1;
                    nx.phase = i2cm_pkg::PH_ST_B;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_ST_B: begin
                    nx.pin_sda = 1'b0;
                    nx.phase = i2cm_pkg::PH_ST_C;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_ST_C: begin
                    nx.pin_scl   = 1'b0;
                    nx.bit_index = 3'd0;
                    nx.phase     = i2cm_pkg::PH_TX_SET;
                end
                i2cm_pkg::PH_TX_SET: begin
                    nx.pin_scl = 1'b0; nx.pin_drv = 1'b1;
                    nx.pin_sda = nx.shift_byte[7];
                    nx.phase   = i2cm_pkg::PH_TX_RISE;
                end
                i2cm_pkg::PH_TX_RISE: begin
                    nx.pin_scl    = 1'b1;
                    nx.shift_byte = {nx.shift_byte[6:0], 1'b0};
                    nx.waiting    = 1'b1; nx.delay_count = delay_ticks;
                    if (nx.bit_index == 3'd7) begin
                        nx.phase = i2cm_pkg::PH_AK_REL;
                    end else begin
                        nx.bit_index = nx.bit_index + 3'd1;
                        nx.phase     = i2cm_pkg::PH_TX_SET;
                    end
                end
                i2cm_pkg::PH_AK_REL: begin
                    nx.pin_scl = 1'b0; nx.pin_drv = 1'b0;
                    nx.phase = i2cm_pkg::PH_AK_RISE;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_AK_RISE: begin
                    nx.pin_scl = 1'b1;
                    nx.phase = i2cm_pkg::PH_AK_CHK;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_AK_CHK: begin
                    nx.pin_scl   = 1'b0;
                    nx.bit_index = 3'd0;
                    if (tick.sda_in) begin
                        // NACK: abort, no stop
                        res.done_res = 1'b1;
                        nx.phase     = i2cm_pkg::PH_IDLE;
                    end else if (nx.stage == i2cm_pkg::STG_ID) begin
                        nx.shift_byte = nx.held_addr;
                        nx.stage      = i2cm_pkg::STG_ADDR;
                        nx.phase      = i2cm_pkg::PH_TX_SET;
                    end else if (nx.stage == i2cm_pkg::STG_RID) begin
                        nx.phase = i2cm_pkg::PH_RX_REL;
                    end else if (nx.read_mode) begin
                        nx.shift_byte = nx.held_id + 8'd1;
                        nx.stage      = i2cm_pkg::STG_RID;
                        nx.phase      = i2cm_pkg::PH_ST_A;
                    end else if (nx.bytes_left != 8'd0) begin
                        nx.shift_byte = tick.wr_data;
                        res.wr_taken  = 1'b1;
                        nx.bytes_left = nx.bytes_left - 8'd1;
                        nx.stage      = i2cm_pkg::STG_DATA;
                        nx.phase      = i2cm_pkg::PH_TX_SET;
                    end else begin
                        nx.phase = i2cm_pkg::PH_SP_A;
                    end
                end
                i2cm_pkg::PH_RX_REL: begin
                    nx.pin_scl = 1'b0; nx.pin_drv = 1'b0;
                    nx.bit_index  = 3'd0;
                    nx.shift_byte = 8'd0;
                    nx.phase = i2cm_pkg::PH_RX_RISE;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_RX_RISE: begin
                    nx.pin_scl = 1'b1;
                    nx.phase = i2cm_pkg::PH_RX_SAMP;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_RX_SAMP: begin
                    nx.shift_byte = {nx.shift_byte[6:0], tick.sda_in};
                    nx.pin_scl    = 1'b0;
                    nx.waiting    = 1'b1; nx.delay_count = delay_ticks;
                    if (nx.bit_index == 3'd7) begin
                        nx.phase = i2cm_pkg::PH_MA_SET;
                    end else begin
                        nx.bit_index = nx.bit_index + 3'd1;
                        nx.phase     = i2cm_pkg::PH_RX_RISE;
                    end
                end
                i2cm_pkg::PH_MA_SET: begin
                    nx.pin_scl = 1'b0; nx.pin_drv = 1'b1;
                    res.rd_last  = (nx.bytes_left <= 8'd1);
                    nx.pin_sda   = res.rd_last;
                    res.rd_valid = 1'b1;
                    res.rd_data  = nx.shift_byte;
                    nx.phase     = i2cm_pkg::PH_MA_RISE;
                end
                i2cm_pkg::PH_MA_RISE: begin
                    nx.pin_scl = 1'b1;
                    nx.phase = i2cm_pkg::PH_MA_FALL;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_MA_FALL: begin
                    nx.pin_scl = 1'b0;
                    if (nx.bytes_left != 8'd0) begin
                        nx.bytes_left = nx.bytes_left - 8'd1;
                    end
                    nx.phase = (nx.bytes_left == 8'd0) ? i2cm_pkg::PH_SP_A
                                                       : i2cm_pkg::PH_RX_REL;
                end
                i2cm_pkg::PH_SP_A: begin
                    nx.pin_drv = 1'b1; nx.pin_sda = 1'b0;
                    nx.phase = i2cm_pkg::PH_SP_B;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_SP_B: begin
                    nx.pin_scl = 1'b1;
                    nx.phase = i2cm_pkg::PH_SP_C;
                    nx.waiting = 1'b1; nx.delay_count = delay_ticks;
                end
                i2cm_pkg::PH_SP_C: begin
                    nx.pin_sda   = 1'b1;
                    res.done_res = 1'b1;
                    res.ok       = 1'b1;
                    nx.phase     = i2cm_pkg::PH_IDLE;
                end
                default: begin
                    nx.phase   = i2cm_pkg::PH_IDLE;
                    nx.waiting = 1'b0;
                end
            endcase
        end

        if (nx.phase == i2cm_pkg::PH_IDLE) begin
            nx.waiting     = 1'b0;
            nx.delay_count = 8'd0;
        end

        res.scl       = nx.pin_scl;
        res.sda_out   = nx.pin_sda;
        res.sda_drive = nx.pin_drv;
        res.busy_res  = (nx.phase != i2cm_pkg::PH_IDLE);
    end

endmodule

FILE: rtl/i2c_master_register_transfer_top.sv
// Top level of the I2C register transfer master: state, config and output registers.
// Each transaction on the s_ channel is one bus timing tick and yields exactly one
// transaction on the m_ channel, carrying the pin levels after that tick plus the
// read/write/done status. A write sends START, device ID, register address and
// byte_count data bytes, then STOP; a read adds a repeated START with ID+1 and
// receives byte_count bytes (zero counts as one), NACKing the last. A NACK on a sent
// byte aborts at once without STOP and reports done with ok low. Rate: one tick per
// clock; the registered result follows in the next cycle. s_ready stays high unless
// the output register holds a result that m_ready has not yet taken, so a sink that
// always accepts sees one tick in every cycle. The delay_ticks register (reset 10)
// sets every bus delay to delay_ticks+1 ticks; write it only while idle (unchecked).
module i2c_master_register_transfer_top (
    input  logic                aclk,
    input  logic                aresetn,
    // tick input
    input  logic                s_valid,
    output logic                s_ready,
    input  i2cm_pkg::in_t       s_data,
    // result output
    output logic                m_valid,
    input  logic                m_ready,
    output i2cm_pkg::out_t      m_data,
    // delay_ticks write port
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    i2cm_pkg::state_t state_reg;
    i2cm_pkg::state_t state_next;
    i2cm_pkg::out_t   res_next;
    i2cm_pkg::out_t   m_data_reg;
    logic             m_valid_reg;
    logic [7:0]       delay_ticks_reg;
    logic             s_fire;

    // Output register empty, or being drained this cycle.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    i2cm_step u_step (
        .st          (state_reg),
        .tick        (s_data),
        .delay_ticks (delay_ticks_reg),
        .nx          (state_next),
        .res         (res_next)
    );

    // Config register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= i2cm_pkg::DELAY_RESET;
        end else if (cfg_valid) begin
            delay_ticks_reg <= cfg_data;
        end
    end

    // Transfer state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2cm_pkg::STATE_RESET;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register: valid flag under reset, payload loads on accept.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= res_next;
        end
    end

endmodule

FILE: rtl/i2cm_checker.sv
// Port-level checker for the I2C register transfer master, with its bind.
`include "assert_macros.svh"

module i2cm_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input i2cm_pkg::out_t m_data
);

    // every accepted tick produces a result next cycle
    `ASSERT_CLK(a_tick_to_result, aclk, aresetn, s_valid && s_ready |=> m_valid)

    // a stalled result holds
    `ASSERT_CLK(a_result_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // a finished transfer is no longer busy, and ok only comes with done
    `ASSERT_CLK(a_done_idle, aclk, aresetn, m_valid && (m_data.done_res || m_data.ok) |-> m_data.done_res && !m_data.busy_res)

    // reset empties the output register
    `ASSERT_CLK_NR(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind i2c_master_register_transfer_top i2cm_checker u_i2cm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
